// ===== sv/idt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package idt_pkg;

	// Table geometry
	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths
	localparam int FUNC_W   = 2;
	localparam int ID_W     = 32;
	localparam int LEN_W    = 24;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 11;
	localparam int ENTRY_W  = ID_W + LEN_W;

	// Request kinds
	localparam logic [FUNC_W-1:0] FN_ADD     = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_LONGEST = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

`default_nettype wire

// ===== sv/id_table_insert_remove_longest.sv =====
// Flow: a request is captured in idle; add, remove and longest scan the filled entries in
//   order to the end, add and remove stopping early on a matching id; a remove that hits
//   then copies the last entry into its slot (move read, move write). Unknown kinds go to done.
// Requests: one at a time, in_stall high outside idle; the scan reads the entry memory one
//   entry per cycle, and a stalled result holds the block in done until it is taken.
// Reset: count, state, scan pointers and result valid clear at once; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module id_table_insert_remove_longest
	import idt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [ID_W-1:0]    entry_id,
	input  wire logic [LEN_W-1:0]   entry_length,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [STAT_W-1:0]       status,
	output logic [COUNT_W-1:0]      entry_count,
	output logic [ID_W-1:0]         best_id,
	output logic [LEN_W-1:0]        best_length
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_SCAN    = 5'b00010,
		S_MOVE_RD = 5'b00100,
		S_MOVE_WR = 5'b01000,
		S_DONE    = 5'b10000
	} state_t;

	state_t               state_q;
	logic [FUNC_W-1:0]    req_func_q;
	logic [ID_W-1:0]      req_id_q;
	logic [LEN_W-1:0]     req_len_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     issue_q;
	logic                 pend_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [IDX_W-1:0]     slot_q;
	logic [ID_W-1:0]      best_id_q;
	logic [LEN_W-1:0]     best_len_q;
	logic [STAT_W-1:0]    res_status_q;
	logic                 out_valid_q;

	// Entry memory, id in the upper bits
	logic [ENTRY_W-1:0]   mem_q [CAPACITY];
	logic [ENTRY_W-1:0]   rd_data_s1;
	logic [IDX_W-1:0]     rd_addr;
	logic                 mem_we;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENTRY_W-1:0]   wr_data;

	logic [ID_W-1:0]      rd_id;
	logic [LEN_W-1:0]     rd_len;
	logic                 is_search;
	logic                 hit;
	logic                 issue_go;
	logic                 scan_end;
	logic                 better;
	logic                 out_free;

	assign rd_id  = rd_data_s1[ENTRY_W-1:LEN_W];
	assign rd_len = rd_data_s1[LEN_W-1:0];

	// Scan control
	always_comb begin
		is_search = req_func_q inside {FN_ADD, FN_REMOVE};
		hit       = (state_q == S_SCAN) && pend_s1 && is_search && (rd_id == req_id_q);
		issue_go  = (state_q == S_SCAN) && (issue_q < count_q) && !hit;
		scan_end  = (state_q == S_SCAN) && (hit || ((issue_q == count_q) && !pend_s1));
		better    = (idx_s1 == '0) || (rd_len > best_len_q) ||
			((rd_len == best_len_q) && (rd_id < best_id_q));
		out_free  = !out_valid_q || !out_stall;
	end

	// Memory address and write selection
	always_comb begin
		rd_addr = issue_q[IDX_W-1:0];
		mem_we  = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = {req_id_q, req_len_q};
		if (state_q == S_MOVE_RD) begin
			rd_addr = IDX_W'(count_q - CNT_W'(1));
		end
		if (scan_end && !hit && (req_func_q == FN_ADD) && (count_q < CNT_W'(CAPACITY))) begin
			mem_we = 1'b1;
		end
		if (state_q == S_MOVE_WR) begin
			mem_we  = 1'b1;
			wr_addr = slot_q;
			wr_data = rd_data_s1;
		end
	end

	// Synchronous memory, one read and one write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Result valid: raised from done, dropped once taken
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					issue_q <= '0;
					pend_s1 <= 1'b0;
					if (in_valid) begin
						if (func inside {FN_ADD, FN_REMOVE, FN_LONGEST}) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					// issue_go is low whenever the scan ends
					pend_s1 <= issue_go;
					if (issue_go) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (scan_end) begin
						if (req_func_q == FN_REMOVE && hit) begin
							state_q <= S_MOVE_RD;
						end else begin
							state_q <= S_DONE;
						end
						if (mem_we) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture, best tracking and result status
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			idx_s1 <= issue_q[IDX_W-1:0];
		end
		case (state_q)
			S_IDLE: begin
				req_func_q   <= func;
				req_id_q     <= entry_id;
				req_len_q    <= entry_length;
				best_id_q    <= '0;
				best_len_q   <= '0;
				res_status_q <= ST_OK;
			end
			S_SCAN: begin
				if (pend_s1 && (req_func_q == FN_LONGEST) && better) begin
					best_id_q  <= rd_id;
					best_len_q <= rd_len;
				end
				if (scan_end) begin
					case (req_func_q)
						FN_ADD: begin
							if (hit) begin
								res_status_q <= ST_MISS;
							end else if (!mem_we) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_OK;
							end
						end
						FN_REMOVE: begin
							slot_q       <= idx_s1;
							res_status_q <= hit ? ST_OK : ST_MISS;
						end
						default: begin
							res_status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status      <= res_status_q;
			entry_count <= COUNT_W'(count_q);
			best_id     <= best_id_q;
			best_length <= best_len_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SCAN || state_q == S_MOVE_WR))
		else $error("memory write outside scan or move");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE_WR) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove did not drop the count");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (CNT_W'(idx_s1) < count_q))
		else $error("scan read beyond filled entries");

endmodule

`default_nettype wire
